FILE: rtl/mcss_pkg.sv
// Package for the multi-channel sample scheduler.
// Holds widths, reset values, register indexes, sequencer states and result types.
// Depends on nothing; every other file of the block imports it.
package mcss_pkg;

  // Channel count and field widths.
  localparam int unsigned NUM_CHANNELS = 7;
  localparam int unsigned CH_W         = 3;
  localparam int unsigned ACC_W        = 20;
  localparam int unsigned PER_W        = 16;
  localparam int unsigned MASK_W       = 7;
  localparam int unsigned CFG_IDX_W    = 4;
  localparam int unsigned CFG_DATA_W   = 16;

  // Tick length and saturation limit of the accumulators.
  localparam logic [ACC_W:0]   TICK_MS    = 21'd10;
  localparam logic [ACC_W-1:0] ACC_MAX    = 20'hFFFFF;
  localparam logic [PER_W-1:0] PERIOD_RST = 16'd200;

  // Configuration register indexes: the enable mask, then one period per channel.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD0 = 4'd1;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  // One trigger result word.
  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [ACC_W-1:0] lateness_ms;
    logic             data_taken;
    logic             last_of_tick;
  } res_t;

  // Outcome of the shared accumulate and compare unit for one channel.
  typedef struct packed {
    logic             trig;
    logic [ACC_W-1:0] lateness;
    logic [ACC_W-1:0] acc_next;
  } acc_res_t;

endpackage

FILE: rtl/mcss_if.sv
// Handshake interfaces of the sample scheduler: tick words in, trigger words out.
// Depends on mcss_pkg for the payload widths.
interface mcss_in_if;
  import mcss_pkg::*;

  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] ready_mask;

  modport source (output valid, output ready_mask, input ready);
  modport sink (input valid, input ready_mask, output ready);
endinterface

interface mcss_out_if;
  import mcss_pkg::*;

  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  channel;
  logic [ACC_W-1:0] lateness_ms;
  logic             data_taken;
  logic             last_of_tick;

  modport source (output valid, output channel, output lateness_ms, output data_taken,
                  output last_of_tick, input ready);
  modport sink (input valid, input channel, input lateness_ms, input data_taken,
                input last_of_tick, output ready);
endinterface

FILE: rtl/mcss_acc_unit.sv
// Shared accumulate, saturate and compare unit, used once per channel step.
// Depends on mcss_pkg for widths, the tick length and the result struct.
module mcss_acc_unit (
  input  logic [mcss_pkg::ACC_W-1:0] elapsed_i,
  input  logic [mcss_pkg::PER_W-1:0] period_i,
  input  logic                       enable_i,
  input  logic                       taken_i,
  output mcss_pkg::acc_res_t         res_o
);
  import mcss_pkg::*;

  logic [ACC_W:0]   sum;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] per_ext;
  logic [ACC_W-1:0] late;
  logic             trig;

  // Add one tick and saturate at the accumulator maximum.
  assign sum = {1'b0, elapsed_i} + TICK_MS;
  assign acc = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];

  // Compare with the period; the difference is the lateness.
  assign per_ext = {{(ACC_W - PER_W){1'b0}}, period_i};
  assign trig    = enable_i && (acc >= per_ext);
  assign late    = acc - per_ext;

  // A disabled channel holds; the period is consumed only when data was taken.
  always_comb begin
    res_o.trig     = trig;
    res_o.lateness = late;
    if (!enable_i) begin
      res_o.acc_next = elapsed_i;
    end else if (trig && taken_i) begin
      res_o.acc_next = late;
    end else begin
      res_o.acc_next = acc;
    end
  end

endmodule

FILE: rtl/multi_channel_sample_scheduler.sv
// Top level of the multi-channel sample scheduler: registers, sequencer, output stage.
// Depends on mcss_pkg, the interfaces in mcss_if.sv and mcss_acc_unit.
//
//   port      dir   word            accepted when
//   in_i      in    ready_mask      in_i.valid && in_i.ready
//   out_o     out   trigger result  out_o.valid && out_o.ready
//   cfg_*     in    register write  cfg_we_i
//
// After a tick is accepted, the walk takes one channel per cycle through the shared add
// and compare unit while the output is not stalled, then flushes the held last result,
// and then returns to idle to accept the next tick.
// Reset clears the accumulators and the enable mask and loads every period with 200.
// A stalled output pauses the channel walk only when a second trigger needs the output.
module multi_channel_sample_scheduler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mcss_in_if.sink                         in_i,
  mcss_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [mcss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mcss_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import mcss_pkg::*;

  state_e            state_q, state_d;
  logic [CH_W-1:0]   idx_q, idx_d;
  logic [MASK_W-1:0] rmask_q, rmask_d;
  logic [MASK_W-1:0] enable_q;
  logic [PER_W-1:0]  period_q [NUM_CHANNELS];
  logic [ACC_W-1:0]  elapsed_q [NUM_CHANNELS];
  res_t              pend_q, pend_d;
  logic              pend_vld_q, pend_vld_d;
  res_t              out_q, out_d;
  logic              out_vld_q, out_vld_d;
  logic              elapsed_we;
  logic              can_push;
  logic              last_ch;
  logic              taken;
  acc_res_t          acc;

  // Configuration registers; writes beyond the list fall through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        period_q[i] <= PERIOD_RST;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_ENABLE) begin
        enable_q <= cfg_wdata_i[MASK_W-1:0];
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (cfg_idx_i == REG_PERIOD0 + CFG_IDX_W'(i)) begin
          period_q[i] <= cfg_wdata_i[PER_W-1:0];
        end
      end
    end
  end

  // Shared unit works on the channel under the walk index.
  assign taken = rmask_q[idx_q];

  mcss_acc_unit u_acc (
    .elapsed_i (elapsed_q[idx_q]),
    .period_i  (period_q[idx_q]),
    .enable_i  (enable_q[idx_q]),
    .taken_i   (taken),
    .res_o     (acc)
  );

  assign can_push = !out_vld_q || out_o.ready;
  assign last_ch  = (idx_q == CH_W'(NUM_CHANNELS - 1));

  // Sequencer. A trigger is held in the pending register so the final one of a tick can be marked.
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    rmask_d    = rmask_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    elapsed_we = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          rmask_d    = in_i.ready_mask;
          idx_d      = '0;
          pend_vld_d = 1'b0;
          state_d    = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!(acc.trig && pend_vld_q && !can_push)) begin
          elapsed_we = 1'b1;
          if (acc.trig) begin
            if (pend_vld_q) begin
              out_d              = pend_q;
              out_d.last_of_tick = 1'b0;
              out_vld_d          = 1'b1;
            end
            pend_d.channel      = idx_q;
            pend_d.lateness_ms  = acc.lateness;
            pend_d.data_taken   = taken;
            pend_d.last_of_tick = 1'b0;
            pend_vld_d          = 1'b1;
          end
          if (last_ch) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = ST_IDLE;
        end else if (can_push) begin
          out_d              = pend_q;
          out_d.last_of_tick = 1'b1;
          out_vld_d          = 1'b1;
          pend_vld_d         = 1'b0;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rmask_q <= rmask_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  // Elapsed-time accumulators, written back one channel per step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        elapsed_q[i] <= '0;
      end
    end else if (elapsed_we) begin
      elapsed_q[idx_q] <= acc.acc_next;
    end
  end

  // Port drive.
  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_vld_q;
  assign out_o.channel      = out_q.channel;
  assign out_o.lateness_ms  = out_q.lateness_ms;
  assign out_o.data_taken   = out_q.data_taken;
  assign out_o.last_of_tick = out_q.last_of_tick;

endmodule

FILE: rtl/mcss_checker.sv
// Port-level checks of the sample scheduler, bound to the top level.
// Depends on mcss_pkg for the channel count and widths.
module mcss_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [mcss_pkg::CH_W-1:0]   out_channel_i,
  input logic [mcss_pkg::ACC_W-1:0]  out_lateness_i,
  input logic                        out_taken_i,
  input logic                        out_last_i
);
  import mcss_pkg::*;

  // A stalled result word holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_channel_i)
      && $stable(out_lateness_i) && $stable(out_taken_i) && $stable(out_last_i))
    else $error("stalled result word changed");

  // After a tick is taken the block is still busy at the last step of the channel walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> ##NUM_CHANNELS !in_ready_i)
    else $error("tick accepted before channel walk finished");

  // No new result appears while the block waits for a tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && !out_valid_i |=> !out_valid_i)
    else $error("result word produced while idle");

  // Only existing channels are reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_channel_i < CH_W'(NUM_CHANNELS))
    else $error("result names a channel that does not exist");

endmodule

bind multi_channel_sample_scheduler mcss_checker u_mcss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_channel_i  (out_o.channel),
  .out_lateness_i (out_o.lateness_ms),
  .out_taken_i    (out_o.data_taken),
  .out_last_i     (out_o.last_of_tick)
);
